@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define LFVL_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");

// Check a property on every clock edge, reset included.
`define LFVL_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");

`endif

@@ rtl/lfvl_pkg.sv @@
// ----------------------------------------------------------------------------
// lfvl_pkg
// Types, constants and arithmetic helpers of the leader-follower velocity law.
// ----------------------------------------------------------------------------
package lfvl_pkg;

    localparam int FRAC = 16;
    localparam int WORD = 24;
    localparam int ZW   = 20;
    localparam int CFGW = 23;

    localparam logic signed [ZW-1:0]   PI_Q      = 20'sd205887;
    localparam logic signed [ZW-1:0]   TWO_PI_Q  = 20'sd411774;
    localparam logic signed [ZW-1:0]   HALF_PI_Q = 20'sd102944;
    localparam logic signed [WORD-1:0] GAIN_Q    = 24'sd39797;

    localparam logic [2:0] REG_GAIN_LON  = 3'd0;
    localparam logic [2:0] REG_GAIN_LAT  = 3'd1;
    localparam logic [2:0] REG_OFF_INV   = 3'd2;
    localparam logic [2:0] REG_DIST      = 3'd3;
    localparam logic [2:0] REG_ANGLE     = 3'd4;
    localparam logic [2:0] REG_LIN_LIMIT = 3'd5;
    localparam logic [2:0] REG_ANG_LIMIT = 3'd6;

    typedef struct packed {
        logic                 flip;
        logic signed [ZW-1:0] z;
    } angle_t;

    // arctangent of 2^-i, Q16, rounded from a 32-bit fraction
    function automatic logic signed [ZW-1:0] atan_q16(input int i);
        logic [33:0] t;
        logic [33:0] r;
        case (i)
            0:  t = 34'd3373259426;
            1:  t = 34'd1991351318;
            2:  t = 34'd1052175346;
            3:  t = 34'd534100635;
            4:  t = 34'd268086748;
            5:  t = 34'd134174063;
            6:  t = 34'd67103403;
            7:  t = 34'd33553749;
            8:  t = 34'd16777131;
            9:  t = 34'd8388597;
            10: t = 34'd4194303;
            11: t = 34'd2097152;
            12: t = 34'd1048576;
            13: t = 34'd524288;
            14: t = 34'd262144;
            15: t = 34'd131072;
            16: t = 34'd65536;
            17: t = 34'd32768;
            18: t = 34'd16384;
            19: t = 34'd8192;
            20: t = 34'd4096;
            21: t = 34'd2048;
            22: t = 34'd1024;
            23: t = 34'd512;
            default: t = 34'd0;
        endcase
        r = (t + 34'd32768) >> 16;
        return signed'(r[ZW-1:0]);
    endfunction

    // wrap into +-pi, then fold beyond +-pi/2
    function automatic angle_t fold_angle(input logic signed [18:0] a);
        logic signed [ZW-1:0] z;
        logic signed [ZW-1:0] w;
        angle_t               o;
        z = ZW'(a);
        if (z > PI_Q) begin
            w = z - TWO_PI_Q;
        end else if (z < -PI_Q) begin
            w = z + TWO_PI_Q;
        end else begin
            w = z;
        end
        if (w > HALF_PI_Q) begin
            o.z    = w - PI_Q;
            o.flip = 1'b1;
        end else if (w < -HALF_PI_Q) begin
            o.z    = w + PI_Q;
            o.flip = 1'b1;
        end else begin
            o.z    = w;
            o.flip = 1'b0;
        end
        return o;
    endfunction

    // product rounded half away from zero, saturated to the word
    function automatic logic signed [WORD-1:0] qmul(input logic signed [WORD:0] a,
                                                    input logic signed [WORD:0] b);
        logic signed [2*WORD+1:0] p;
        logic signed [2*WORD+1:0] pn;
        logic [2*WORD:0]          m;
        logic [2*WORD:0]          r;
        logic                     neg;
        p   = a * b;
        pn  = -p;
        neg = p[2*WORD+1];
        m   = neg ? pn[2*WORD:0] : p[2*WORD:0];
        r   = (m + ((2*WORD+1)'(1) << (FRAC - 1))) >> FRAC;
        if (r >= ((2*WORD+1)'(1) << (WORD - 1))) begin
            return neg ? {1'b1, {(WORD-1){1'b0}}} : {1'b0, {(WORD-1){1'b1}}};
        end
        return neg ? -r[WORD-1:0] : r[WORD-1:0];
    endfunction

    function automatic logic signed [WORD-1:0] sat_word(input logic signed [WORD+2:0] v);
        if (v > (WORD+3)'(signed'({1'b0, {(WORD-1){1'b1}}}))) begin
            return {1'b0, {(WORD-1){1'b1}}};
        end
        if (v < -(WORD+3)'(signed'({1'b0, 1'b1, {(WORD-1){1'b0}}}))) begin
            return {1'b1, {(WORD-1){1'b0}}};
        end
        return v[WORD-1:0];
    endfunction

    function automatic logic signed [WORD:0] ext_s(input logic signed [WORD-1:0] v);
        return {v[WORD-1], v};
    endfunction

    function automatic logic signed [WORD:0] ext_u(input logic [CFGW-1:0] v);
        return {2'b00, v};
    endfunction

    function automatic logic signed [WORD+2:0] wide(input logic signed [WORD-1:0] v);
        return {{3{v[WORD-1]}}, v};
    endfunction

endpackage

@@ rtl/lfvl_cordic.sv @@
// ----------------------------------------------------------------------------
// lfvl_cordic
// Pipelined rotation-mode CORDIC, one stage per iteration, sine and cosine out.
// ----------------------------------------------------------------------------
module lfvl_cordic #(
    parameter int STAGES = 16
) (
    input  logic                   aclk,
    input  logic                   en,
    input  lfvl_pkg::angle_t       ang,
    output logic signed [23:0]     sin_q,
    output logic signed [23:0]     cos_q
);
    import lfvl_pkg::*;

    logic signed [WORD-1:0] x_reg [0:STAGES-1];
    logic signed [WORD-1:0] y_reg [0:STAGES-1];
    logic signed [ZW-1:0]   z_reg [0:STAGES-1];
    logic                   f_reg [0:STAGES-1];
    logic signed [WORD-1:0] sin_reg;
    logic signed [WORD-1:0] cos_reg;

    genvar i;
    generate
        for (i = 0; i < STAGES; i++) begin : g_stage
            localparam logic signed [ZW-1:0] DA = atan_q16(i);
            logic signed [WORD-1:0] xi;
            logic signed [WORD-1:0] yi;
            logic signed [ZW-1:0]   zi;
            logic                   fi;
            if (i == 0) begin : g_first
                assign xi = GAIN_Q;
                assign yi = '0;
                assign zi = ang.z;
                assign fi = ang.flip;
            end else begin : g_next
                assign xi = x_reg[i-1];
                assign yi = y_reg[i-1];
                assign zi = z_reg[i-1];
                assign fi = f_reg[i-1];
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    if (!zi[ZW-1]) begin
                        x_reg[i] <= xi - (yi >>> i);
                        y_reg[i] <= yi + (xi >>> i);
                        z_reg[i] <= zi - DA;
                    end else begin
                        x_reg[i] <= xi + (yi >>> i);
                        y_reg[i] <= yi - (xi >>> i);
                        z_reg[i] <= zi + DA;
                    end
                    f_reg[i] <= fi;
                end
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= f_reg[STAGES-1] ? -x_reg[STAGES-1] : x_reg[STAGES-1];
            sin_reg <= f_reg[STAGES-1] ? -y_reg[STAGES-1] : y_reg[STAGES-1];
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

@@ rtl/leader_follower_velocity_law.sv @@
// ----------------------------------------------------------------------------
// leader_follower_velocity_law
// Follower linear and angular commands from the pose relative to the leader.
//
//  channel | direction | transfer
//  s_*     | in        | pose and leader speeds, one item per transfer
//  m_*     | out       | clamped commands and clamp flags
//  cfg_*   | in        | register write, index and data
//
// The CORDIC, 16 stages by default, sets most of the latency; one item
// per cycle while not stalled. The whole pipeline holds while m_tvalid
// waits on m_tready. aresetn resets valid bits and config registers only.
// ----------------------------------------------------------------------------
module leader_follower_velocity_law #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    // rel_x[23:0], rel_y[47:24], rel_yaw[66:48], leader_linear[90:67],
    // leader_angular[114:91], zero fill
    input  logic [119:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // follower_linear[23:0], follower_angular[47:24]
    output logic [47:0]   m_tdata,
    // linear_clamped[0], angular_clamped[1]
    output logic [1:0]    m_tuser,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [22:0]   cfg_data
);
    import lfvl_pkg::*;

    localparam int DEPTH = CORDIC_STAGES + 10;

    typedef struct packed {
        logic signed [WORD-1:0] rx;
        logic signed [WORD-1:0] ry;
        logic signed [WORD-1:0] vl;
        logic signed [WORD-1:0] wl;
    } carry_t;

    logic [CFGW-1:0]    gain_lon_reg, gain_lat_reg, off_inv_reg, dist_reg;
    logic [CFGW-1:0]    lin_limit_reg, ang_limit_reg;
    logic signed [18:0] angle_reg;

    logic               adv;
    logic [DEPTH-1:0]   vld_reg;
    logic               out_vld_reg;

    carry_t             in_reg;
    logic signed [18:0] yaw_reg;
    angle_t             ang_d_reg, ang_y_reg;
    carry_t             dly_reg [0:CORDIC_STAGES+1];

    logic signed [WORD-1:0] sin_d, cos_d, sin_y, cos_y;

    logic signed [WORD-1:0] ldc_reg, lds_reg, yw_reg, xw_reg;
    logic signed [WORD-1:0] rx1_reg, ry1_reg, vl1_reg, sy1_reg, cy1_reg;
    logic signed [WORD-1:0] a_reg, b_reg, yw2_reg, xw2_reg, vl2_reg, sy2_reg, cy2_reg;
    logic signed [WORD-1:0] ga_reg, gb_reg, yw3_reg, xw3_reg, vl3_reg, sy3_reg, cy3_reg;
    logic signed [WORD-1:0] p_reg, q_reg, sy4_reg, cy4_reg;
    logic signed [WORD-1:0] pc_reg, qs_reg, qc_reg, ps_reg;
    logic signed [WORD-1:0] lin_reg, angp_reg;
    logic signed [WORD-1:0] lin7_reg, ang_reg;
    logic signed [WORD-1:0] lin_out_reg, ang_out_reg;
    logic                   lhit_reg, ahit_reg;

    logic signed [WORD:0]   lin_lim, ang_lim;
    logic signed [WORD-1:0] lin_next, ang_next;
    logic                   lhit_next, ahit_next;

    assign adv       = !out_vld_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_lon_reg  <= 23'd98304;
            gain_lat_reg  <= 23'd98304;
            off_inv_reg   <= 23'd655360;
            dist_reg      <= 23'd65536;
            angle_reg     <= '0;
            lin_limit_reg <= 23'd98304;
            ang_limit_reg <= 23'd39322;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_GAIN_LON:  gain_lon_reg  <= cfg_data;
                REG_GAIN_LAT:  gain_lat_reg  <= cfg_data;
                REG_OFF_INV:   off_inv_reg   <= cfg_data;
                REG_DIST:      dist_reg      <= cfg_data;
                REG_ANGLE:     angle_reg     <= signed'(cfg_data[18:0]);
                REG_LIN_LIMIT: lin_limit_reg <= cfg_data;
                REG_ANG_LIMIT: ang_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[DEPTH-2:0], s_tvalid};
            out_vld_reg <= vld_reg[DEPTH-1];
        end
    end

    // capture and angle fold
    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg.rx  <= signed'(s_tdata[23:0]);
            in_reg.ry  <= signed'(s_tdata[47:24]);
            yaw_reg    <= signed'(s_tdata[66:48]);
            in_reg.vl  <= signed'(s_tdata[90:67]);
            in_reg.wl  <= signed'(s_tdata[114:91]);
            ang_d_reg  <= fold_angle(angle_reg);
            ang_y_reg  <= fold_angle(yaw_reg);
            dly_reg[0] <= in_reg;
            for (int k = 1; k <= CORDIC_STAGES + 1; k++) begin
                dly_reg[k] <= dly_reg[k-1];
            end
        end
    end

    lfvl_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_d (
        .aclk (aclk),
        .en   (adv),
        .ang  (ang_d_reg),
        .sin_q(sin_d),
        .cos_q(cos_d)
    );

    lfvl_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_y (
        .aclk (aclk),
        .en   (adv),
        .ang  (ang_y_reg),
        .sin_q(sin_y),
        .cos_q(cos_y)
    );

    // arithmetic stages
    always_ff @(posedge aclk) begin
        if (adv) begin
            ldc_reg <= qmul(ext_u(dist_reg), ext_s(cos_d));
            lds_reg <= qmul(ext_u(dist_reg), ext_s(sin_d));
            yw_reg  <= qmul(ext_s(dly_reg[CORDIC_STAGES+1].ry),
                            ext_s(dly_reg[CORDIC_STAGES+1].wl));
            xw_reg  <= qmul(ext_s(dly_reg[CORDIC_STAGES+1].rx),
                            ext_s(dly_reg[CORDIC_STAGES+1].wl));
            rx1_reg <= dly_reg[CORDIC_STAGES+1].rx;
            ry1_reg <= dly_reg[CORDIC_STAGES+1].ry;
            vl1_reg <= dly_reg[CORDIC_STAGES+1].vl;
            sy1_reg <= sin_y;
            cy1_reg <= cos_y;

            a_reg   <= sat_word(wide(ldc_reg) - wide(rx1_reg));
            b_reg   <= sat_word(wide(lds_reg) - wide(ry1_reg));
            yw2_reg <= yw_reg;
            xw2_reg <= xw_reg;
            vl2_reg <= vl1_reg;
            sy2_reg <= sy1_reg;
            cy2_reg <= cy1_reg;

            ga_reg  <= qmul(ext_u(gain_lon_reg), ext_s(a_reg));
            gb_reg  <= qmul(ext_u(gain_lat_reg), ext_s(b_reg));
            yw3_reg <= yw2_reg;
            xw3_reg <= xw2_reg;
            vl3_reg <= vl2_reg;
            sy3_reg <= sy2_reg;
            cy3_reg <= cy2_reg;

            p_reg   <= sat_word(wide(ga_reg) - wide(yw3_reg) + wide(vl3_reg));
            q_reg   <= sat_word(wide(gb_reg) + wide(xw3_reg));
            sy4_reg <= sy3_reg;
            cy4_reg <= cy3_reg;

            pc_reg  <= qmul(ext_s(p_reg), ext_s(cy4_reg));
            qs_reg  <= qmul(ext_s(q_reg), ext_s(sy4_reg));
            qc_reg  <= qmul(ext_s(q_reg), ext_s(cy4_reg));
            ps_reg  <= qmul(ext_s(p_reg), ext_s(sy4_reg));

            lin_reg  <= sat_word(wide(pc_reg) + wide(qs_reg));
            angp_reg <= sat_word(wide(qc_reg) - wide(ps_reg));

            ang_reg  <= qmul(ext_s(angp_reg), ext_u(off_inv_reg));
            lin7_reg <= lin_reg;

            lin_out_reg <= lin_next;
            ang_out_reg <= ang_next;
            lhit_reg    <= lhit_next;
            ahit_reg    <= ahit_next;
        end
    end

    // clamp to limits
    always_comb begin
        lin_lim   = ext_u(lin_limit_reg);
        ang_lim   = ext_u(ang_limit_reg);
        lin_next  = lin7_reg;
        lhit_next = 1'b0;
        if (ext_s(lin7_reg) > lin_lim) begin
            lin_next  = lin_lim[WORD-1:0];
            lhit_next = 1'b1;
        end else if (ext_s(lin7_reg) < -lin_lim) begin
            lin_next  = -lin_lim[WORD-1:0];
            lhit_next = 1'b1;
        end
        ang_next  = ang_reg;
        ahit_next = 1'b0;
        if (ext_s(ang_reg) > ang_lim) begin
            ang_next  = ang_lim[WORD-1:0];
            ahit_next = 1'b1;
        end else if (ext_s(ang_reg) < -ang_lim) begin
            ang_next  = -ang_lim[WORD-1:0];
            ahit_next = 1'b1;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {ang_out_reg, lin_out_reg};
    assign m_tuser  = {ahit_reg, lhit_reg};

endmodule

@@ rtl/lfvl_checker.sv @@
// ----------------------------------------------------------------------------
// lfvl_checker
// Port-level checks of the velocity law block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfvl_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [119:0] s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [47:0]  m_tdata,
    input logic [1:0]   m_tuser,
    input logic         cfg_valid,
    input logic         cfg_ready,
    input logic [2:0]   cfg_index,
    input logic [22:0]  cfg_data
);

    `LFVL_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid)
    `LFVL_ASSERT(a_ready_follows_out, aclk, aresetn, s_tready == (!m_tvalid || m_tready))
    `LFVL_ASSERT(a_stall_holds, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `LFVL_ASSERT(a_cfg_open, aclk, aresetn, cfg_ready)

endmodule

bind leader_follower_velocity_law lfvl_checker u_lfvl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
);

@@ bench/leader_follower_velocity_law_tb.sv @@
// ----------------------------------------------------------------------------
// leader_follower_velocity_law_tb
// Self-checking bench for the leader-follower velocity law. A driver sends
// pose and speed transfers from a queue, a monitor compares each command
// transfer with a bit-accurate fixed-point prediction, and register writes
// between phases walk the gains, set-point and limits through their extremes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module leader_follower_velocity_law_tb;
    import lfvl_pkg::*;

    typedef struct packed {
        logic signed [23:0] wl;
        logic signed [23:0] vl;
        logic signed [18:0] yaw;
        logic signed [23:0] py;
        logic signed [23:0] px;
    } pose_t;

    typedef struct {
        logic signed [23:0] lin;
        logic signed [23:0] ang;
        logic               lin_hit;
        logic               ang_hit;
    } command_t;

    localparam longint WMAX  = 64'sd8388607;
    localparam longint WMIN  = -64'sd8388608;
    localparam longint PI_L  = 64'sd205887;
    localparam longint HPI_L = 64'sd102944;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [119:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [22:0] cfg_data;

    pose_t    pending_poses[$];
    command_t expected_cmds[$];
    int       errors;
    bit       calm;
    bit       send_hold;
    bit       rx_stall_req;
    int       rx_stall_cnt;
    int       quiet_cycles;

    longint k_lon, k_lat, off_inv, set_dist, angle, lin_lim, ang_lim;

    leader_follower_velocity_law dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic longint sat24(input longint v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        longint p;
        longint m;
        bit     n;
        p = a * b;
        n = p < 0;
        m = n ? -p : p;
        m = (m + 64'sd32768) >>> 16;
        if (m > 64'sd8388608) m = 64'sd8388608;
        return sat24(n ? -m : m);
    endfunction

    function automatic void sin_cos_q16(input longint a, output longint s, output longint c);
        longint atan_tab[16];
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     flip;
        atan_tab = '{64'sd3373259426, 1991351318, 1052175346, 534100635, 268086748,
                     134174063, 67103403, 33553749, 16777131, 8388597, 4194303,
                     2097152, 1048576, 524288, 262144, 131072};
        x = 64'sd39797;
        y = 0;
        flip = 0;
        z = a % (2 * PI_L);
        if (z > PI_L) z -= 2 * PI_L;
        if (z < -PI_L) z += 2 * PI_L;
        if (z > HPI_L) begin
            z -= PI_L;
            flip = 1;
        end else if (z < -HPI_L) begin
            z += PI_L;
            flip = 1;
        end
        for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx;
                y += dy;
                z -= (atan_tab[i] + 64'sd32768) >>> 16;
            end else begin
                x += dx;
                y -= dy;
                z += (atan_tab[i] + 64'sd32768) >>> 16;
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic command_t follower_command(input pose_t p);
        longint   px, py, vl, wl;
        longint   st, ct, sy, cy, ea, eb, lp, lq, lin, ang;
        command_t r;
        px = p.px;
        py = p.py;
        vl = p.vl;
        wl = p.wl;
        sin_cos_q16(angle, st, ct);
        sin_cos_q16(longint'(p.yaw), sy, cy);
        ea  = sat24(fx_mul(set_dist, ct) - px);
        eb  = sat24(fx_mul(set_dist, st) - py);
        lp  = sat24(fx_mul(k_lon, ea) - fx_mul(py, wl) + vl);
        lq  = sat24(fx_mul(k_lat, eb) + fx_mul(px, wl));
        lin = sat24(fx_mul(lp, cy) + fx_mul(lq, sy));
        ang = sat24(fx_mul(lq, cy) - fx_mul(lp, sy));
        ang = fx_mul(ang, off_inv);
        r.lin_hit = 0;
        r.ang_hit = 0;
        if (lin > lin_lim) begin
            lin = lin_lim;
            r.lin_hit = 1;
        end else if (lin < -lin_lim) begin
            lin = -lin_lim;
            r.lin_hit = 1;
        end
        if (ang > ang_lim) begin
            ang = ang_lim;
            r.ang_hit = 1;
        end else if (ang < -ang_lim) begin
            ang = -ang_lim;
            r.ang_hit = 1;
        end
        r.lin = lin[23:0];
        r.ang = ang[23:0];
        return r;
    endfunction

    function automatic logic signed [23:0] rand_word(input int mode);
        case (mode)
            0: return 24'($signed($urandom_range(1048576)) - 524288);
            1: return 24'($signed($urandom_range(65536)) - 32768);
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic pose_t rand_pose();
        pose_t p;
        int    mode;
        mode  = $urandom_range(9) < 6 ? 0 : ($urandom_range(1) ? 1 : 2);
        p.px  = rand_word(mode);
        p.py  = rand_word(mode);
        p.vl  = rand_word(mode);
        p.wl  = rand_word(mode);
        p.yaw = 19'($signed($urandom_range(411774)) - 205887);
        return p;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_cmds.push_back(follower_command(pending_poses.pop_front()));
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (pending_poses.size() > 0 && !send_hold
                         && (calm || $urandom_range(99) >= 16)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {5'b0, pending_poses[0]};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        command_t e;
        if (!aresetn) begin
            m_tready     <= 1'b0;
            rx_stall_cnt <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_cmds.size() == 0) begin
                    $error("unexpected command transfer %h", m_tdata);
                    errors++;
                end else begin
                    e = expected_cmds.pop_front();
                    if (m_tdata[23:0] !== e.lin) begin
                        $error("follower_linear exp %0d got %0d", e.lin,
                               $signed(m_tdata[23:0]));
                        errors++;
                    end
                    if (m_tdata[47:24] !== e.ang) begin
                        $error("follower_angular exp %0d got %0d", e.ang,
                               $signed(m_tdata[47:24]));
                        errors++;
                    end
                    if (m_tuser[0] !== e.lin_hit) begin
                        $error("linear_clamped exp %0b got %0b", e.lin_hit, m_tuser[0]);
                        errors++;
                    end
                    if (m_tuser[1] !== e.ang_hit) begin
                        $error("angular_clamped exp %0b got %0b", e.ang_hit, m_tuser[1]);
                        errors++;
                    end
                end
            end
            if (rx_stall_req && rx_stall_cnt == 0) begin
                rx_stall_cnt <= 300;
                m_tready     <= 1'b0;
            end else if (rx_stall_cnt > 0) begin
                rx_stall_cnt <= rx_stall_cnt - 1;
                m_tready     <= 1'b0;
            end else begin
                m_tready <= calm || $urandom_range(99) >= 16;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 3000) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_poses.size() > 0 || s_tvalid || expected_cmds.size() > 0)
            @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input longint val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[22:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GAIN_LON:  k_lon    = val & 64'h7FFFFF;
            REG_GAIN_LAT:  k_lat    = val & 64'h7FFFFF;
            REG_OFF_INV:   off_inv  = val & 64'h7FFFFF;
            REG_DIST:      set_dist = val & 64'h7FFFFF;
            REG_ANGLE:     angle    = longint'($signed(val[18:0]));
            REG_LIN_LIMIT: lin_lim  = val & 64'h7FFFFF;
            REG_ANG_LIMIT: ang_lim  = val & 64'h7FFFFF;
            default: ;
        endcase
    endtask

    task automatic load_random(input int n);
        repeat (n) pending_poses.push_back(rand_pose());
    endtask

    initial begin
        pose_t p;
        logic signed [23:0] ext[4];
        errors       = 0;
        calm         = 0;
        send_hold    = 0;
        rx_stall_req = 0;
        quiet_cycles = 0;
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_GAIN_LON;
        cfg_data     = '0;
        k_lon = 98304; k_lat = 98304; off_inv = 655360; set_dist = 65536;
        angle = 0; lin_lim = 98304; ang_lim = 39322;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes and angle fold boundaries
        ext = '{24'sh7FFFFF, -24'sh800000, 24'sd0, -24'sd1};
        for (int i = 0; i < 4; i++) begin
            p = '{wl: ext[i], vl: ext[i], yaw: 19'sd0, py: ext[i], px: ext[i]};
            pending_poses.push_back(p);
            p = '{wl: ext[3-i], vl: ext[i], yaw: 19'sd0, py: ext[(i+1)%4], px: ext[3-i]};
            pending_poses.push_back(p);
        end
        foreach (ext[i]) begin
            p = rand_pose();
            p.yaw = i == 0 ? 19'sd205887 : i == 1 ? -19'sd205887 :
                    i == 2 ? 19'sd102944 : 19'sd102945;
            pending_poses.push_back(p);
            p.yaw = -p.yaw;
            pending_poses.push_back(p);
        end
        load_random(380);
        // let the block back up behind a stalled receiver
        repeat (100) @(posedge aclk);
        rx_stall_req <= 1'b1;
        @(posedge aclk);
        rx_stall_req <= 1'b0;
        wait_drained();

        // maximum gains and set-point, wide limits
        write_reg(REG_GAIN_LON, 8388607);
        write_reg(REG_GAIN_LAT, 8388607);
        write_reg(REG_OFF_INV, 8388607);
        write_reg(REG_DIST, 8388607);
        write_reg(REG_ANGLE, 205887);
        write_reg(REG_LIN_LIMIT, 8388607);
        write_reg(REG_ANG_LIMIT, 8388607);
        calm = 1;
        load_random(380);
        wait_drained();
        calm = 0;

        // zero gains and zero limits, smallest offset inverse
        write_reg(REG_GAIN_LON, 0);
        write_reg(REG_GAIN_LAT, 0);
        write_reg(REG_OFF_INV, 1);
        write_reg(REG_DIST, 0);
        write_reg(REG_ANGLE, -205887);
        write_reg(REG_LIN_LIMIT, 0);
        write_reg(REG_ANG_LIMIT, 0);
        load_random(200);
        // hold the sender until every command is back
        repeat (120) @(posedge aclk);
        send_hold = 1;
        while (expected_cmds.size() > 0 || s_tvalid) @(posedge aclk);
        send_hold = 0;
        load_random(180);
        wait_drained();

        // random settings
        repeat (3) begin
            write_reg(REG_GAIN_LON, $urandom_range(262144));
            write_reg(REG_GAIN_LAT, $urandom_range(262144));
            write_reg(REG_OFF_INV, $urandom_range(1048576, 1));
            write_reg(REG_DIST, $urandom_range(327680));
            write_reg(REG_ANGLE, $signed($urandom_range(411774)) - 205887);
            write_reg(REG_LIN_LIMIT, $urandom_range(327680));
            write_reg(REG_ANG_LIMIT, $urandom_range(327680));
            load_random(250);
            wait_drained();
        end

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
